// ===== design/ray_rectangle_hit_and_reflect_core_assert.svh =====
// assertion helpers for the ray rectangle core
`ifndef RAY_RECTANGLE_HIT_AND_REFLECT_CORE_ASSERT_SVH
`define RAY_RECTANGLE_HIT_AND_REFLECT_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RRHR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RRHR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rrhr_pkg.sv =====
package rrhr_pkg;

    typedef logic signed [31:0] word_t;
    typedef logic signed [63:0] prod_t;
    typedef word_t vec3_t [3];

    // commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_TRACE = 1'b1;

    // register select, paddr bit 2
    localparam logic REG_PLATE_COUNT = 1'b0;
    localparam logic REG_STRIP_WIDTH = 1'b1;

    localparam logic [2:0]  PLATE_COUNT_RST = 3'd2;
    localparam logic [30:0] STRIP_WIDTH_RST = 31'd1028915;

    // table word layout of one rectangle
    localparam int RECT_WORDS = 14;
    localparam int W_A    = 0;
    localparam int W_E1   = 3;
    localparam int W_E2   = 6;
    localparam int W_N    = 9;
    localparam int W_LEN1 = 12;
    localparam int W_LEN2 = 13;

    // pipeline stage numbers, stage 0 is the input register
    localparam int DIV_STEPS = 32;
    localparam int ST_DIV0   = 4;
    localparam int ST_T      = ST_DIV0 + DIV_STEPS + 1;
    localparam int ST_TP     = ST_T + 1;
    localparam int ST_H      = ST_TP + 1;
    localparam int ST_DF     = ST_H + 1;
    localparam int ST_EP     = ST_DF + 1;
    localparam int ST_IN     = ST_EP + 1;
    localparam int PIPE_LAST = ST_IN;

    localparam word_t S32_MAX = 32'sh7FFFFFFF;
    localparam word_t S32_MIN = 32'sh80000000;

    typedef struct {
        vec3_t pos;
        vec3_t dir;
        logic  bad;
    } ctx_t;

    typedef struct {
        logic  hit;
        logic  on_strip;
        word_t cos;
        vec3_t h;
        vec3_t nd;
    } rrhr_res_t;

    typedef struct {
        logic       hit;
        logic [2:0] hit_rect;
        logic       on_strip;
        word_t      cos;
        vec3_t      pos;
        vec3_t      dir;
    } rrhr_out_t;

    // restoring divider state: qp shifts dividend bits out and quotient bits in
    typedef struct packed {
        logic [34:0] rem;
        logic [31:0] qp;
        logic [34:0] dmag;
        logic        ovf;
        logic        neg;
        logic        dz;
        word_t       cos;
    } div_t;

    function automatic word_t sat36(logic signed [35:0] v);
        if (v[35:31] != {5{v[35]}})
        begin
            return v[35] ? S32_MIN : S32_MAX;
        end
        return v[31:0];
    endfunction

    // sum of three products over 2^30, rounded half up
    function automatic logic signed [34:0] rnd_dot(prod_t p0, prod_t p1, prod_t p2);
        logic signed [65:0] s;
        s = 66'(p0) + 66'(p1) + 66'(p2) + 66'sd536870912;
        return s[64:30];
    endfunction

    function automatic logic signed [33:0] rnd30(prod_t p);
        prod_t s;
        s = p + 64'sd536870912;
        return s[63:30];
    endfunction

    function automatic logic signed [34:0] rnd29(prod_t p);
        prod_t s;
        s = p + 64'sd268435456;
        return s[63:29];
    endfunction

    function automatic div_t div_step(div_t s);
        logic [35:0] rs;
        logic [35:0] rd;
        logic        ge;
        div_t        n;
        rs = {s.rem, s.qp[31]};
        rd = rs - {1'b0, s.dmag};
        ge = rs >= {1'b0, s.dmag};
        n = s;
        n.rem = ge ? rd[34:0] : rs[34:0];
        n.qp = {s.qp[30:0], ge};
        return n;
    endfunction

endpackage

// ===== design/rrhr_if.sv =====
interface rrhr_in_if;
    import rrhr_pkg::*;

    logic       valid;
    logic       ready;
    logic       command;
    logic [2:0] rect_index;
    logic [3:0] word_index;
    word_t      word_value;
    word_t      pos_x;
    word_t      pos_y;
    word_t      pos_z;
    word_t      dir_x;
    word_t      dir_y;
    word_t      dir_z;
    logic       photon_bad;

    modport source (
        output valid, command, rect_index, word_index, word_value,
               pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, photon_bad,
        input  ready
    );
    modport sink (
        input  valid, command, rect_index, word_index, word_value,
               pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, photon_bad,
        output ready
    );
endinterface

interface rrhr_out_if;
    import rrhr_pkg::*;

    logic       valid;
    logic       ready;
    logic       hit;
    logic [2:0] hit_rect;
    logic       on_strip;
    word_t      cos_incidence;
    word_t      out_pos_x;
    word_t      out_pos_y;
    word_t      out_pos_z;
    word_t      out_dir_x;
    word_t      out_dir_y;
    word_t      out_dir_z;

    modport source (
        output valid, hit, hit_rect, on_strip, cos_incidence,
               out_pos_x, out_pos_y, out_pos_z, out_dir_x, out_dir_y, out_dir_z,
        input  ready
    );
    modport sink (
        input  valid, hit, hit_rect, on_strip, cos_incidence,
               out_pos_x, out_pos_y, out_pos_z, out_dir_x, out_dir_y, out_dir_z,
        output ready
    );
endinterface

// ===== design/rrhr_rect_unit.sv =====
module rrhr_rect_unit (
    input  logic                clk,
    input  logic                adv,
    input  rrhr_pkg::word_t     words [rrhr_pkg::RECT_WORDS],
    input  logic [30:0]         strip_width,
    input  rrhr_pkg::vec3_t     pos_u1,
    input  rrhr_pkg::vec3_t     dir_u1,
    input  rrhr_pkg::vec3_t     dir_tp,
    input  rrhr_pkg::vec3_t     pos_h,
    input  rrhr_pkg::vec3_t     dir_in,
    output rrhr_pkg::rrhr_res_t res
);
    import rrhr_pkg::*;

    prod_t              dn_reg [3];
    vec3_t              df_reg;
    logic signed [34:0] d2_reg;
    prod_t              pn_reg [3];
    logic signed [34:0] d3_reg;
    word_t              num_reg;
    div_t               dv_reg [DIV_STEPS+1];
    word_t              t_reg;
    word_t              cos_t_reg;
    logic               dz_t_reg;
    prod_t              tp_reg [3];
    word_t              cos_tp_reg;
    logic               dz_tp_reg;
    vec3_t              h_reg;
    word_t              cos_h_reg;
    logic               dz_h_reg;
    vec3_t              df2_reg;
    vec3_t              h_df_reg;
    word_t              cos_df_reg;
    logic               dz_df_reg;
    prod_t              e1p_reg [3];
    prod_t              e2p_reg [3];
    prod_t              cp_reg [3];
    vec3_t              h_ep_reg;
    word_t              cos_ep_reg;
    logic               dz_ep_reg;
    rrhr_res_t          res_reg;

    logic [31:0]        nmag;
    logic signed [34:0] dmag;
    div_t               div_init;
    logic [31:0]        quo;
    div_t               div_last;
    word_t              t_next;
    logic signed [34:0] xx;
    logic signed [34:0] yy;
    logic               in_rect;

    // division set-up: |num| * 2^30 over |d|, top dividend bits preloaded
    always_comb
    begin
        nmag = num_reg[31] ? 32'(-num_reg) : 32'(num_reg);
        dmag = d3_reg[34] ? -d3_reg : d3_reg;
        div_init.rem  = {5'b0, nmag[31:2]};
        div_init.qp   = {nmag[1:0], 30'b0};
        div_init.dmag = 35'(dmag);
        div_init.ovf  = {5'b0, nmag[31:2]} >= 35'(dmag);
        div_init.neg  = num_reg[31] ^ d3_reg[34];
        div_init.dz   = d3_reg == '0;
        div_init.cos  = sat36(36'(d3_reg));
    end

    // quotient truncated toward zero, then saturated
    always_comb
    begin
        div_last = dv_reg[DIV_STEPS];
        quo = div_last.qp;
        if (div_last.neg)
        begin
            if (div_last.ovf || (quo[31] && (|quo[30:0])))
            begin
                t_next = S32_MIN;
            end
            else
            begin
                t_next = word_t'(-quo);
            end
        end
        else
        begin
            if (div_last.ovf || quo[31])
            begin
                t_next = S32_MAX;
            end
            else
            begin
                t_next = word_t'(quo);
            end
        end
    end

    always_comb
    begin
        xx = rnd_dot(e1p_reg[0], e1p_reg[1], e1p_reg[2]);
        yy = rnd_dot(e2p_reg[0], e2p_reg[1], e2p_reg[2]);
        in_rect = !xx[34] && (xx < 35'(words[W_LEN1]))
               && !yy[34] && (yy < 35'(words[W_LEN2]));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dn_reg[i] <= 64'(dir_u1[i]) * 64'(words[W_N+i]);
                df_reg[i] <= sat36(36'(words[W_A+i]) - 36'(pos_u1[i]));
                pn_reg[i] <= 64'(df_reg[i]) * 64'(words[W_N+i]);
            end
            d2_reg <= rnd_dot(dn_reg[0], dn_reg[1], dn_reg[2]);
            d3_reg <= d2_reg;
            num_reg <= sat36(36'(rnd_dot(pn_reg[0], pn_reg[1], pn_reg[2])));

            dv_reg[0] <= div_init;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_reg[k+1] <= div_step(dv_reg[k]);
            end

            t_reg     <= t_next;
            cos_t_reg <= div_last.cos;
            dz_t_reg  <= div_last.dz;

            for (int i = 0; i < 3; i++)
            begin
                tp_reg[i]   <= 64'(t_reg) * 64'(dir_tp[i]);
                h_reg[i]    <= sat36(36'(pos_h[i]) + 36'(rnd30(tp_reg[i])));
                df2_reg[i]  <= sat36(36'(h_reg[i]) - 36'(words[W_A+i]));
                h_df_reg[i] <= h_reg[i];
                e1p_reg[i]  <= 64'(df2_reg[i]) * 64'(words[W_E1+i]);
                e2p_reg[i]  <= 64'(df2_reg[i]) * 64'(words[W_E2+i]);
                cp_reg[i]   <= 64'(cos_df_reg) * 64'(words[W_N+i]);
                h_ep_reg[i] <= h_df_reg[i];
                res_reg.h[i]  <= h_ep_reg[i];
                res_reg.nd[i] <= sat36(36'(dir_in[i]) - 36'(rnd29(cp_reg[i])));
            end
            cos_tp_reg <= cos_t_reg;
            dz_tp_reg  <= dz_t_reg;
            cos_h_reg  <= cos_tp_reg;
            dz_h_reg   <= dz_tp_reg;
            cos_df_reg <= cos_h_reg;
            dz_df_reg  <= dz_h_reg;
            cos_ep_reg <= cos_df_reg;
            dz_ep_reg  <= dz_df_reg;

            res_reg.hit      <= !dz_ep_reg && in_rect;
            res_reg.on_strip <= xx < $signed({4'b0, strip_width});
            res_reg.cos      <= cos_ep_reg;
        end
    end

    assign res = res_reg;

endmodule

// ===== design/ray_rectangle_hit_and_reflect_core.sv =====
// a trace transfer shows its result after every pipeline stage and the output register,
// most of it spent in the 32-stage restoring divider pipeline
// throughput: one trace per cycle, the pipeline only holds while a result waits at the output
// a table load is taken only once no trace is left in the pipeline
// reset clears the stage valid bits, the output valid bit and both config registers
// the plate table is not reset and holds garbage until loaded
module ray_rectangle_hit_and_reflect_core #(
    parameter int PLATES_MAX = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rrhr_in_if.sink     in_ch,
    rrhr_out_if.source  out_ch
);
    import rrhr_pkg::*;
    `include "ray_rectangle_hit_and_reflect_core_assert.svh"

    localparam int RECT_MAX = 2 * PLATES_MAX;
    localparam int RLIM_W   = $clog2(RECT_MAX + 1);

    // config registers
    logic [2:0]  plate_count_reg;
    logic [30:0] strip_width_reg;

    // plate table, one row of words per rectangle; each unit reads its own row
    word_t tbl_reg [RECT_MAX][RECT_WORDS];

    // photon context and valid bit per stage
    ctx_t                 ctx_reg [PIPE_LAST+1];
    logic [PIPE_LAST:0]   vld_reg;

    rrhr_res_t            res [RECT_MAX];

    rrhr_out_t            out_reg;
    rrhr_out_t            out_next;
    logic                 out_vld_reg;

    logic                 adv;
    logic                 busy;
    logic                 acc;
    logic                 trace_acc;
    logic                 load_acc;
    logic [RLIM_W-1:0]    rect_lim;

    // ---------------------------------------------------------------
    // apb config port, register select on paddr bit 2
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plate_count_reg <= PLATE_COUNT_RST;
            strip_width_reg <= STRIP_WIDTH_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_PLATE_COUNT: plate_count_reg <= pwdata[2:0];
                REG_STRIP_WIDTH: strip_width_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PLATE_COUNT: prdata = {29'b0, plate_count_reg};
            REG_STRIP_WIDTH: prdata = {1'b0, strip_width_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // flow control: the whole pipeline moves when the output register
    // is free or being drained; a load waits for in-flight traces so
    // every trace sees the table as it was when the trace was taken
    // ---------------------------------------------------------------
    assign adv  = !out_vld_reg || out_ch.ready;
    assign busy = |vld_reg;

    assign in_ch.ready = (in_ch.command == CMD_TRACE) ? adv : !busy;
    assign acc         = in_ch.valid && in_ch.ready;
    assign trace_acc   = acc && (in_ch.command == CMD_TRACE);
    assign load_acc    = acc && (in_ch.command == CMD_LOAD);

    // table write; word indexes past the last word match nothing
    always_ff @(posedge clk)
    begin
        if (load_acc)
        begin
            for (int r = 0; r < RECT_MAX; r++)
            begin
                for (int w = 0; w < RECT_WORDS; w++)
                begin
                    if (int'(in_ch.rect_index) == r && in_ch.word_index == 4'(w))
                    begin
                        tbl_reg[r][w] <= in_ch.word_value;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[PIPE_LAST-1:0], trace_acc};
            out_vld_reg <= vld_reg[PIPE_LAST];
        end
    end

    // photon context travels beside the per-rectangle pipelines
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[0].pos[0] <= in_ch.pos_x;
            ctx_reg[0].pos[1] <= in_ch.pos_y;
            ctx_reg[0].pos[2] <= in_ch.pos_z;
            ctx_reg[0].dir[0] <= in_ch.dir_x;
            ctx_reg[0].dir[1] <= in_ch.dir_y;
            ctx_reg[0].dir[2] <= in_ch.dir_z;
            ctx_reg[0].bad    <= in_ch.photon_bad;
            for (int s = 1; s <= PIPE_LAST; s++)
            begin
                ctx_reg[s] <= ctx_reg[s-1];
            end
            out_reg <= out_next;
        end
    end

    // ---------------------------------------------------------------
    // one hit-test pipeline per rectangle, all fed the same photon:
    // dot products, plane parameter divide, hit point, inside test
    // and mirrored direction
    // ---------------------------------------------------------------
    for (genvar g = 0; g < RECT_MAX; g++)
    begin : g_rect
        rrhr_rect_unit u_rect (
            .clk         (clk),
            .adv         (adv),
            .words       (tbl_reg[g]),
            .strip_width (strip_width_reg),
            .pos_u1      (ctx_reg[0].pos),
            .dir_u1      (ctx_reg[0].dir),
            .dir_tp      (ctx_reg[ST_TP-1].dir),
            .pos_h       (ctx_reg[ST_H-1].pos),
            .dir_in      (ctx_reg[ST_IN-1].dir),
            .res         (res[g])
        );
    end

    // rectangles in use, plate count clipped to the table size
    always_comb
    begin
        if (int'(plate_count_reg) > PLATES_MAX)
        begin
            rect_lim = RLIM_W'(RECT_MAX);
        end
        else
        begin
            rect_lim = RLIM_W'(2 * int'(plate_count_reg));
        end
    end

    // first hit wins: scan from the top so the lowest index is written last
    always_comb
    begin
        out_next.hit      = 1'b0;
        out_next.hit_rect = '0;
        out_next.on_strip = 1'b0;
        out_next.cos      = '0;
        out_next.pos      = ctx_reg[PIPE_LAST].pos;
        out_next.dir      = ctx_reg[PIPE_LAST].dir;
        for (int r = RECT_MAX - 1; r >= 0; r--)
        begin
            if (RLIM_W'(r) < rect_lim && res[r].hit && !ctx_reg[PIPE_LAST].bad)
            begin
                out_next.hit      = 1'b1;
                out_next.hit_rect = 3'(r);
                out_next.on_strip = res[r].on_strip;
                out_next.cos      = res[r].cos;
                out_next.pos      = res[r].h;
                out_next.dir      = res[r].nd;
            end
        end
    end

    assign out_ch.valid         = out_vld_reg;
    assign out_ch.hit           = out_reg.hit;
    assign out_ch.hit_rect      = out_reg.hit_rect;
    assign out_ch.on_strip      = out_reg.on_strip;
    assign out_ch.cos_incidence = out_reg.cos;
    assign out_ch.out_pos_x     = out_reg.pos[0];
    assign out_ch.out_pos_y     = out_reg.pos[1];
    assign out_ch.out_pos_z     = out_reg.pos[2];
    assign out_ch.out_dir_x     = out_reg.dir[0];
    assign out_ch.out_dir_y     = out_reg.dir[1];
    assign out_ch.out_dir_z     = out_reg.dir[2];

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `RRHR_ASSERT_NOW(a_load_idle, load_acc, !busy, "table load taken with traces in flight")
    `RRHR_ASSERT_NOW(a_hit_in_range, out_vld_reg && out_reg.hit,
        RLIM_W'(out_reg.hit_rect) < rect_lim, "hit on a rectangle not in use")
    `RRHR_ASSERT_NOW(a_miss_clean, out_vld_reg && !out_reg.hit,
        out_reg.cos == 0 && !out_reg.on_strip && out_reg.hit_rect == 0,
        "miss result carries hit fields")
    `RRHR_ASSERT_NEXT(a_stall_hold, out_vld_reg && !out_ch.ready,
        $stable(vld_reg), "pipeline moved during output stall")

endmodule
